>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, clocked on clk, off while arst_n is low.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// Next-cycle implication, clocked on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`endif

>>> rtl/ssf_pkg.sv
// Shared types, register indexes and saturation helper of the spring force block.
package ssf_pkg;
	localparam int K_W = 31;
	localparam int OUT_W = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_RESIST_COMPRESSION = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEFINITE_MODE = 1'd1;
	localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;
	localparam logic [K_W-1:0] SAT_U31 = 31'h7FFF_FFFF;

	typedef struct packed {
		logic en;
		logic valid;
	} stg_ctl_t;

	// Clamp a sign and magnitude to a signed 32-bit result; big flags magnitude bits above 32.
	function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic big,
			input logic [OUT_W-1:0] mag);
		logic [OUT_W-1:0] res;
		if (neg) begin
			res = (big || mag[OUT_W-1]) ? SAT_NEG : (~mag + 1'b1);
		end else begin
			res = (big || mag[OUT_W-1]) ? SAT_POS : mag;
		end
		return res;
	endfunction
endpackage

>>> rtl/ssf_ifs.sv
// Item channels of the spring force block: spring in, result out.
interface ssf_in_if
	import ssf_pkg::*;
#(
	parameter int COORD_WIDTH = 32
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] pos_i_x;
	logic signed [COORD_WIDTH-1:0] pos_i_y;
	logic signed [COORD_WIDTH-1:0] pos_i_z;
	logic signed [COORD_WIDTH-1:0] pos_j_x;
	logic signed [COORD_WIDTH-1:0] pos_j_y;
	logic signed [COORD_WIDTH-1:0] pos_j_z;
	logic [K_W-1:0] rest_length;
	logic [K_W-1:0] spring_stiffness;

	modport source(output valid, pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z,
		rest_length, spring_stiffness, input ready);
	modport sink(input valid, pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z,
		rest_length, spring_stiffness, output ready);
endinterface

interface ssf_out_if
	import ssf_pkg::*;
;
	logic valid;
	logic ready;
	logic signed [OUT_W-1:0] force_x;
	logic signed [OUT_W-1:0] force_y;
	logic signed [OUT_W-1:0] force_z;
	logic [K_W-1:0] cur_length;
	logic signed [OUT_W-1:0] tangent_alpha;
	logic signed [OUT_W-1:0] tangent_beta;
	logic [K_W-1:0] energy_term;

	modport source(output valid, force_x, force_y, force_z, cur_length, tangent_alpha,
		tangent_beta, energy_term, input ready);
	modport sink(input valid, force_x, force_y, force_z, cur_length, tangent_alpha,
		tangent_beta, energy_term, output ready);
endinterface

>>> rtl/ssf_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a side payload.
module ssf_sqrt
	import ssf_pkg::*;
#(
	parameter int RADW = 68,
	parameter int PW = 8
) (
	input logic clk,
	input logic arst_n,
	input stg_ctl_t ctl,
	input logic [RADW-1:0] rad,
	input logic [PW-1:0] pay_in,
	output logic valid_out,
	output logic [RADW/2-1:0] root,
	output logic [PW-1:0] pay_out
);
	localparam int RTW = RADW / 2;
	localparam int REMW = RTW + 3;

	logic v_s [RTW+1];
	logic [REMW-1:0] rem_s [RTW+1];
	logic [RTW-1:0] root_s [RTW+1];
	logic [RADW-1:0] rad_s [RTW+1];
	logic [PW-1:0] pay_s [RTW+1];

	assign v_s[0] = ctl.valid;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign rad_s[0] = rad;
	assign pay_s[0] = pay_in;

	for (genvar i = 0; i < RTW; i++) begin : g_stage
		logic [REMW-1:0] acc;
		logic [REMW-1:0] trial;
		logic ge;

		// bring down the next two radicand bits, try root*4+1
		assign acc = {rem_s[i][REMW-3:0], rad_s[i][RADW-1 -: 2]};
		assign trial = {1'b0, root_s[i], 2'b01};
		assign ge = acc >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (ctl.en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[i+1] <= ge ? acc - trial : acc;
				root_s[i+1] <= {root_s[i][RTW-2:0], ge};
				rad_s[i+1] <= {rad_s[i][RADW-3:0], 2'b00};
				pay_s[i+1] <= pay_s[i];
			end
		end
	end

	assign valid_out = v_s[RTW];
	assign root = root_s[RTW];
	assign pay_out = pay_s[RTW];
endmodule

>>> rtl/ssf_div.sv
// Pipelined restoring divider, lanes sharing one divisor, one quotient bit per stage.
module ssf_div
	import ssf_pkg::*;
#(
	parameter int DVW = 33,
	parameter int QDW = 62,
	parameter int NL = 4,
	parameter int PW = 8
) (
	input logic clk,
	input logic arst_n,
	input stg_ctl_t ctl,
	input logic [DVW-1:0] divisor,
	input logic [QDW-1:0] dvd [NL],
	input logic [PW-1:0] pay_in,
	output logic valid_out,
	output logic [QDW-1:0] quo [NL],
	output logic [PW-1:0] pay_out
);
	logic v_s [QDW+1];
	logic [DVW-1:0] dv_s [QDW+1];
	logic [PW-1:0] pay_s [QDW+1];
	logic [DVW-1:0] rem_s [QDW+1][NL];
	logic [QDW-1:0] dq_s [QDW+1][NL];

	assign v_s[0] = ctl.valid;
	assign dv_s[0] = divisor;
	assign pay_s[0] = pay_in;

	for (genvar l = 0; l < NL; l++) begin : g_init
		assign rem_s[0][l] = '0;
		assign dq_s[0][l] = dvd[l];
		assign quo[l] = dq_s[QDW][l];
	end

	for (genvar i = 0; i < QDW; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (ctl.en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				dv_s[i+1] <= dv_s[i];
				pay_s[i+1] <= pay_s[i];
			end
		end

		for (genvar l = 0; l < NL; l++) begin : g_lane
			logic [DVW:0] acc;
			logic ge;

			// quotient bits shift in where dividend bits shift out
			assign acc = {rem_s[i][l], dq_s[i][l][QDW-1]};
			assign ge = acc >= {1'b0, dv_s[i]};

			always_ff @(posedge clk) begin
				if (ctl.en) begin
					rem_s[i+1][l] <= ge ? DVW'(acc - {1'b0, dv_s[i]}) : acc[DVW-1:0];
					dq_s[i+1][l] <= {dq_s[i][l][QDW-2:0], ge};
				end
			end
		end
	end

	assign valid_out = v_s[QDW];
	assign pay_out = pay_s[QDW];
endmodule

>>> rtl/spring_stiffness_and_force_top.sv
// Spring element: length, direction, elastic force, energy and tangent stiffness.
// Order: s1 to s4, square root pipeline, s5 to s7, divider pipeline, s8, s9 result register.
// Throughput: one spring per cycle when no result stalls; sqrt and divider fully pipelined.
// A stalled result register freezes the whole pipeline; no item is dropped or repeated.
// Reset clears all valid bits and sets both mode registers to 1.
module spring_stiffness_and_force_top
	import ssf_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [REG_IDX_W-1:0] cfg_index,
	input logic cfg_data,
	ssf_in_if.sink spring,
	ssf_out_if.source result
);
	localparam int CW = COORD_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int DW = CW + 1;
	localparam int LW = CW + 1;
	localparam int RADW = 2 * DW + 2;
	localparam int RTW = RADW / 2;
	localparam int SW = (LW > K_W) ? LW : K_W;
	localparam int KRW = 2 * K_W;
	localparam int QDW = (DW + F > KRW) ? DW + F : KRW;
	localparam int TW = SW + K_W - F;
	localparam int UW = F + 1;
	localparam int FPW = TW + UW;
	localparam int AW = F + 34;
	localparam int ALW = AW / 2;
	localparam int AHW = AW - ALW;
	localparam int EPW = K_W + AW;
	localparam int EPL = K_W + ALW;
	localparam int EPH = K_W + AHW;
	localparam int CMPW = (LW + 7 > K_W) ? LW + 7 : K_W;
	localparam int AFW = 2 * SW - F;
	localparam int MXW = (AFW > AW) ? AFW : AW;
	localparam int CLW = (LW > K_W) ? LW : K_W;
	localparam logic [AW-1:0] A_LIM = {1'b1, {(AW-1){1'b0}}};
	localparam logic [UW-1:0] UNIT_ONE = {1'b1, {F{1'b0}}};

	typedef struct packed {
		logic [2:0][DW-1:0] dm;
		logic [2:0] un;
		logic [K_W-1:0] k;
		logic [K_W-1:0] rest;
		logic [KRW-1:0] kr;
	} sq_pay_t;

	typedef struct packed {
		logic [2:0] un;
		logic zlen;
		logic sneg;
		logic rot;
		logic ztan;
		logic [LW-1:0] len;
		logic [K_W-1:0] k;
		logic [TW-1:0] t;
		logic [AW-1:0] a;
	} dv_pay_t;

	localparam int SQ_PW = $bits(sq_pay_t);
	localparam int DV_PW = $bits(dv_pay_t);

	logic resist_q;
	logic def_mode_q;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resist_q <= 1'b1;
			def_mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESIST_COMPRESSION: resist_q <= cfg_data;
				REG_DEFINITE_MODE: def_mode_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic v_s9;
	assign adv = !v_s9 || result.ready;
	assign spring.ready = adv;

	// s1: coordinate differences, k*rest
	logic v_s1;
	logic signed [DW-1:0] d_s1 [3];
	logic [K_W-1:0] k_s1, rest_s1;
	logic [KRW-1:0] kr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= spring.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0] <= $signed({spring.pos_j_x[CW-1], spring.pos_j_x})
				- $signed({spring.pos_i_x[CW-1], spring.pos_i_x});
			d_s1[1] <= $signed({spring.pos_j_y[CW-1], spring.pos_j_y})
				- $signed({spring.pos_i_y[CW-1], spring.pos_i_y});
			d_s1[2] <= $signed({spring.pos_j_z[CW-1], spring.pos_j_z})
				- $signed({spring.pos_i_z[CW-1], spring.pos_i_z});
			k_s1 <= spring.spring_stiffness;
			rest_s1 <= spring.rest_length;
			kr_s1 <= KRW'(spring.spring_stiffness) * KRW'(spring.rest_length);
		end
	end

	// s2: magnitudes and signs
	logic v_s2;
	logic [DW-1:0] dm_s2 [3];
	logic [2:0] un_s2;
	logic [K_W-1:0] k_s2, rest_s2;
	logic [KRW-1:0] kr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				un_s2[c] <= d_s1[c][DW-1];
				dm_s2[c] <= d_s1[c][DW-1] ? DW'(~d_s1[c] + 1'b1) : DW'(d_s1[c]);
			end
			k_s2 <= k_s1;
			rest_s2 <= rest_s1;
			kr_s2 <= kr_s1;
		end
	end

	// s3: squares
	logic v_s3;
	logic [2*DW-1:0] sq_s3 [3];
	logic [DW-1:0] dm_s3 [3];
	logic [2:0] un_s3;
	logic [K_W-1:0] k_s3, rest_s3;
	logic [KRW-1:0] kr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				sq_s3[c] <= (2*DW)'(dm_s2[c]) * (2*DW)'(dm_s2[c]);
				dm_s3[c] <= dm_s2[c];
			end
			un_s3 <= un_s2;
			k_s3 <= k_s2;
			rest_s3 <= rest_s2;
			kr_s3 <= kr_s2;
		end
	end

	// s4: squared length
	logic v_s4;
	logic [RADW-1:0] sum_s4;
	sq_pay_t sp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4 <= RADW'(sq_s3[0]) + RADW'(sq_s3[1]) + RADW'(sq_s3[2]);
			for (int c = 0; c < 3; c++) sp_s4.dm[c] <= dm_s3[c];
			sp_s4.un <= un_s3;
			sp_s4.k <= k_s3;
			sp_s4.rest <= rest_s3;
			sp_s4.kr <= kr_s3;
		end
	end

	stg_ctl_t sq_ctl;
	logic sq_v;
	logic [RTW-1:0] sq_root;
	logic [SQ_PW-1:0] sq_pay_o;
	sq_pay_t sq_po;

	assign sq_ctl.en = adv;
	assign sq_ctl.valid = v_s4;
	assign sq_po = sq_pay_t'(sq_pay_o);

	ssf_sqrt #(
		.RADW(RADW),
		.PW(SQ_PW)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(sq_ctl),
		.rad(sum_s4),
		.pay_in(sp_s4),
		.valid_out(sq_v),
		.root(sq_root),
		.pay_out(sq_pay_o)
	);

	// s5: stretch, modes
	logic [LW-1:0] len_w;
	logic [SW-1:0] ext_len, ext_rest;
	logic lt_w;
	assign len_w = sq_root[LW-1:0];
	assign ext_len = SW'(len_w);
	assign ext_rest = SW'(sq_po.rest);
	assign lt_w = ext_len < ext_rest;

	logic v_s5, sneg_s5, rot_s5, ztan_s5, zlen_s5;
	logic [LW-1:0] len_s5;
	logic [SW-1:0] smag_s5;
	logic [2:0][DW-1:0] dm_s5;
	logic [2:0] un_s5;
	logic [K_W-1:0] k_s5;
	logic [KRW-1:0] kr_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= sq_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s5 <= len_w;
			sneg_s5 <= lt_w;
			smag_s5 <= lt_w ? ext_rest - ext_len : ext_len - ext_rest;
			rot_s5 <= def_mode_q ? (ext_len > ext_rest)
				: ((CMPW'(len_w) * CMPW'(7'd100)) > CMPW'(sq_po.rest));
			ztan_s5 <= !resist_q && lt_w;
			zlen_s5 <= (len_w == '0);
			dm_s5 <= sq_po.dm;
			un_s5 <= sq_po.un;
			k_s5 <= sq_po.k;
			kr_s5 <= sq_po.kr;
		end
	end

	// s6: k*stretch, stretch squared
	logic v_s6, sneg_s6, rot_s6, ztan_s6, zlen_s6;
	logic [LW-1:0] len_s6;
	logic [K_W+SW-1:0] kt_s6;
	logic [2*SW-1:0] ssq_s6;
	logic [2:0][DW-1:0] dm_s6;
	logic [2:0] un_s6;
	logic [K_W-1:0] k_s6;
	logic [KRW-1:0] kr_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kt_s6 <= (K_W+SW)'(k_s5) * (K_W+SW)'(smag_s5);
			ssq_s6 <= (2*SW)'(smag_s5) * (2*SW)'(smag_s5);
			len_s6 <= len_s5;
			sneg_s6 <= sneg_s5;
			rot_s6 <= rot_s5;
			ztan_s6 <= ztan_s5;
			zlen_s6 <= zlen_s5;
			dm_s6 <= dm_s5;
			un_s6 <= un_s5;
			k_s6 <= k_s5;
			kr_s6 <= kr_s5;
		end
	end

	// s7: scale down; clamp the squared stretch where the energy saturates anyway
	logic [MXW-1:0] a_ext;
	assign a_ext = MXW'(ssq_s6[2*SW-1:F]);

	logic v_s7;
	dv_pay_t dp_s7;
	logic [2:0][DW-1:0] dm_s7;
	logic [KRW-1:0] kr_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dp_s7.t <= kt_s6[K_W+SW-1:F];
			dp_s7.a <= (a_ext > MXW'(A_LIM)) ? A_LIM : AW'(a_ext);
			dp_s7.un <= un_s6;
			dp_s7.zlen <= zlen_s6;
			dp_s7.sneg <= sneg_s6;
			dp_s7.rot <= rot_s6;
			dp_s7.ztan <= ztan_s6;
			dp_s7.len <= len_s6;
			dp_s7.k <= k_s6;
			dm_s7 <= dm_s6;
			kr_s7 <= kr_s6;
		end
	end

	stg_ctl_t dv_ctl;
	logic dv_v;
	logic [QDW-1:0] dvd_w [4];
	logic [QDW-1:0] quo_w [4];
	logic [DV_PW-1:0] dv_pay_o;
	dv_pay_t dv_po;

	assign dv_ctl.en = adv;
	assign dv_ctl.valid = v_s7;
	assign dv_po = dv_pay_t'(dv_pay_o);
	assign dvd_w[0] = QDW'(dm_s7[0]) << F;
	assign dvd_w[1] = QDW'(dm_s7[1]) << F;
	assign dvd_w[2] = QDW'(dm_s7[2]) << F;
	assign dvd_w[3] = QDW'(kr_s7);

	ssf_div #(
		.DVW(LW),
		.QDW(QDW),
		.NL(4),
		.PW(DV_PW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(dv_ctl),
		.divisor(dp_s7.len),
		.dvd(dvd_w),
		.pay_in(dp_s7),
		.valid_out(dv_v),
		.quo(quo_w),
		.pay_out(dv_pay_o)
	);

	// s8: force and energy products, alpha difference
	logic [UW-1:0] um_w [3];
	logic [QDW-1:0] kq_w;
	logic qgt_w;

	assign kq_w = QDW'(dv_po.k);
	assign qgt_w = quo_w[3] > kq_w;

	for (genvar c = 0; c < 3; c++) begin : g_unit
		// zero length: direction is +x
		if (c == 0) begin : g_x
			assign um_w[c] = dv_po.zlen ? UNIT_ONE : quo_w[c][UW-1:0];
		end else begin : g_yz
			assign um_w[c] = dv_po.zlen ? '0 : quo_w[c][UW-1:0];
		end
	end

	logic v_s8, qgt_s8, rot_s8, ztan_s8;
	logic [FPW-1:0] fprod_s8 [3];
	logic [2:0] fneg_s8;
	logic [EPL-1:0] elo_s8;
	logic [EPH-1:0] ehi_s8;
	logic [QDW-1:0] q_s8, qd_s8;
	logic [LW-1:0] len_s8;
	logic [K_W-1:0] k_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= dv_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				fprod_s8[c] <= FPW'(dv_po.t) * FPW'(um_w[c]);
				fneg_s8[c] <= dv_po.sneg != (!dv_po.zlen && dv_po.un[c]);
			end
			// split the energy product into two halves, summed in the next stage
			elo_s8 <= EPL'(dv_po.k) * EPL'(dv_po.a[ALW-1:0]);
			ehi_s8 <= EPH'(dv_po.k) * EPH'(dv_po.a[AW-1:ALW]);
			q_s8 <= quo_w[3];
			qgt_s8 <= qgt_w;
			qd_s8 <= qgt_w ? quo_w[3] - kq_w : kq_w - quo_w[3];
			rot_s8 <= dv_po.rot;
			ztan_s8 <= dv_po.ztan;
			len_s8 <= dv_po.len;
			k_s8 <= dv_po.k;
		end
	end

	// s9: saturate into the result register
	logic [CLW-1:0] len_ext;
	assign len_ext = CLW'(len_s8);

	logic [EPW-1:0] eprod_w;
	assign eprod_w = EPW'(elo_s8) + (EPW'(ehi_s8) << ALW);

	logic [OUT_W-1:0] force_s9 [3];
	logic [K_W-1:0] cur_s9, energy_s9;
	logic [OUT_W-1:0] alpha_s9, beta_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (adv) v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				force_s9[c] <= sat_out(fneg_s8[c], |fprod_s8[c][FPW-1:F+32],
					fprod_s8[c][F+31:F]);
			end
			cur_s9 <= (len_ext > CLW'(SAT_U31)) ? SAT_U31 : len_ext[K_W-1:0];
			if (ztan_s8) begin
				alpha_s9 <= '0;
				beta_s9 <= '0;
				energy_s9 <= '0;
			end else begin
				if (rot_s8) begin
					alpha_s9 <= sat_out(qgt_s8, |qd_s8[QDW-1:32], qd_s8[31:0]);
					beta_s9 <= sat_out(1'b0, |q_s8[QDW-1:32], q_s8[31:0]);
				end else begin
					alpha_s9 <= '0;
					beta_s9 <= {1'b0, k_s8};
				end
				energy_s9 <= (|eprod_w[EPW-1:F+32]) ? SAT_U31 : eprod_w[F+31:F+1];
			end
		end
	end

	assign result.valid = v_s9;
	assign result.force_x = force_s9[0];
	assign result.force_y = force_s9[1];
	assign result.force_z = force_s9[2];
	assign result.cur_length = cur_s9;
	assign result.tangent_alpha = alpha_s9;
	assign result.tangent_beta = beta_s9;
	assign result.energy_term = energy_s9;
endmodule

>>> rtl/ssf_chk.sv
// Port-level checks of the spring force block, bound to its top level.
`include "assert_macros.svh"

module ssf_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic beta_msb
);
	// a stalled result freezes intake
	`ASSERT_SAME(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
	`ASSERT_SAME(a_ready_follows_out, out_ready, in_ready)
	`ASSERT_SAME(a_beta_not_neg, out_valid, !beta_msb)
	`ASSERT_SAME(a_empty_after_reset, $rose(arst_n), !out_valid)
	`ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid)
endmodule

bind spring_stiffness_and_force_top ssf_chk u_ssf_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(spring.valid),
	.in_ready(spring.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.beta_msb(result.tangent_beta[31])
);

>>> tb/testbench.sv
// Self-checking testbench of the spring force block: streamed springs against a local predictor.
`timescale 1ns / 1ps
module testbench;
	import ssf_pkg::*;

	typedef struct {
		logic [31:0] pix, piy, piz, pjx, pjy, pjz;
		logic [30:0] rest, k;
	} spring_t;

	typedef struct {
		logic [31:0] fx, fy, fz;
		logic [30:0] len;
		logic [31:0] alpha, beta;
		logic [30:0] energy;
	} spring_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic cfg_data;

	ssf_in_if #(.COORD_WIDTH(32)) spring_ch();
	ssf_out_if result_ch();

	spring_stiffness_and_force_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.spring(spring_ch.sink),
		.result(result_ch.source)
	);

	spring_t pending_springs[$];
	spring_res_t expected_results[$];
	logic resist_sh, definite_sh;
	bit idle_on;
	bit hold_request;
	int hold_left;
	int errors;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [31:0] clamp_s32(bit neg, logic [127:0] mag);
		if (neg)
			return (mag >= 128'h8000_0000) ? SAT_NEG : (32'd0 - mag[31:0]);
		return (mag > 128'h7FFF_FFFF) ? SAT_POS : mag[31:0];
	endfunction

	function automatic spring_res_t calc_spring(spring_t s);
		spring_res_t r;
		logic [33:0] d[3];
		logic [32:0] dm[3];
		bit un[3];
		logic [127:0] sum, um[3], t, f, a, e;
		logic [63:0] len, cand, smag, q;
		logic [31:0] pi[3], pj[3];
		bit sneg, rot;
		pi[0] = s.pix; pi[1] = s.piy; pi[2] = s.piz;
		pj[0] = s.pjx; pj[1] = s.pjy; pj[2] = s.pjz;
		sum = '0;
		for (int c = 0; c < 3; c++) begin
			d[c] = {{2{pj[c][31]}}, pj[c]} - {{2{pi[c][31]}}, pi[c]};
			un[c] = d[c][33];
			dm[c] = un[c] ? 33'(-d[c]) : d[c][32:0];
			sum = sum + 128'(dm[c]) * 128'(dm[c]);
		end
		len = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = len | (64'd1 << b);
			if (128'(cand) * 128'(cand) <= sum)
				len = cand;
		end
		for (int c = 0; c < 3; c++) begin
			if (len == 0) begin
				um[c] = (c == 0) ? 128'd65536 : 128'd0;
				un[c] = 0;
			end else begin
				um[c] = (128'(dm[c]) << 16) / 128'(len);
			end
		end
		sneg = len < 64'(s.rest);
		smag = sneg ? 64'(s.rest) - len : len - 64'(s.rest);
		t = (128'(s.k) * 128'(smag)) >> 16;
		f = (t * um[0]) >> 16;
		r.fx = clamp_s32(sneg != un[0], f);
		f = (t * um[1]) >> 16;
		r.fy = clamp_s32(sneg != un[1], f);
		f = (t * um[2]) >> 16;
		r.fz = clamp_s32(sneg != un[2], f);
		r.len = (len > 64'h7FFF_FFFF) ? SAT_U31 : len[30:0];
		if (!resist_sh && sneg) begin
			r.alpha = '0;
			r.beta = '0;
			r.energy = '0;
			return r;
		end
		if (definite_sh)
			rot = len > 64'(s.rest);
		else
			rot = 128'(len) * 128'd100 > 128'(s.rest);
		if (rot) begin
			q = (64'(s.k) * 64'(s.rest)) / len;
			if (q > 64'(s.k))
				r.alpha = clamp_s32(1, 128'(q - 64'(s.k)));
			else
				r.alpha = clamp_s32(0, 128'(64'(s.k) - q));
			r.beta = clamp_s32(0, 128'(q));
		end else begin
			r.alpha = '0;
			r.beta = {1'b0, s.k};
		end
		a = (128'(smag) * 128'(smag)) >> 16;
		e = (128'(s.k) * a) >> 17;
		r.energy = (e > 128'h7FFF_FFFF) ? SAT_U31 : e[30:0];
		return r;
	endfunction

	// Driver: hold an offered item until it is taken, then move to the next one.
	always @(posedge clk or negedge arst_n) begin
		bit stalled;
		spring_t nxt;
		if (!arst_n) begin
			spring_ch.valid <= 1'b0;
		end else begin
			stalled = spring_ch.valid && !spring_ch.ready;
			if (spring_ch.valid && spring_ch.ready) begin
				expected_results.push_back(calc_spring(pending_springs[0]));
				void'(pending_springs.pop_front());
			end
			if (!stalled) begin
				if (pending_springs.size() > 0 &&
						!(idle_on && $urandom_range(99) < 6)) begin
					nxt = pending_springs[0];
					spring_ch.valid <= 1'b1;
					spring_ch.pos_i_x <= nxt.pix;
					spring_ch.pos_i_y <= nxt.piy;
					spring_ch.pos_i_z <= nxt.piz;
					spring_ch.pos_j_x <= nxt.pjx;
					spring_ch.pos_j_y <= nxt.pjy;
					spring_ch.pos_j_z <= nxt.pjz;
					spring_ch.rest_length <= nxt.rest;
					spring_ch.spring_stiffness <= nxt.k;
				end else begin
					spring_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Count down a long receiver hold-off.
	always @(posedge clk) begin
		if (hold_request)
			hold_left <= 500;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Monitor: compare each result item with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		spring_res_t x;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with no prediction waiting");
					errors++;
				end else begin
					x = expected_results.pop_front();
					check_field("force_x", x.fx, result_ch.force_x);
					check_field("force_y", x.fy, result_ch.force_y);
					check_field("force_z", x.fz, result_ch.force_z);
					check_field("cur_length", {1'b0, x.len}, {1'b0, result_ch.cur_length});
					check_field("tangent_alpha", x.alpha, result_ch.tangent_alpha);
					check_field("tangent_beta", x.beta, result_ch.tangent_beta);
					check_field("energy_term", {1'b0, x.energy},
						{1'b0, result_ch.energy_term});
				end
			end
			result_ch.ready <= !(hold_left > 0 || hold_request) &&
				!(idle_on && $urandom_range(99) < 6);
		end
	end

	function automatic spring_t mk(logic [31:0] ix, iy, iz, jx, jy, jz,
			logic [30:0] rest, k);
		spring_t s;
		s.pix = ix; s.piy = iy; s.piz = iz;
		s.pjx = jx; s.pjy = jy; s.pjz = jz;
		s.rest = rest; s.k = k;
		return s;
	endfunction

	function automatic logic [31:0] near(logic [31:0] base, int span);
		return base + 32'($urandom_range(2 * span) - span);
	endfunction

	// Mostly short springs with rest lengths of a similar size, some fully random.
	function automatic spring_t rand_spring();
		spring_t s;
		int sel;
		logic [63:0] l;
		sel = $urandom_range(9);
		s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			31'($urandom), 31'($urandom));
		if (sel < 7) begin
			s.pjx = near(s.pix, 1 << $urandom_range(4, 22));
			s.pjy = near(s.piy, 1 << $urandom_range(4, 22));
			s.pjz = near(s.piz, 1 << $urandom_range(4, 22));
			if (sel < 2)
				s.pjz = s.piz;
			l = 64'($urandom_range(1 << 22));
			s.rest = 31'(l);
			s.k = 31'($urandom_range(1 << $urandom_range(1, 30)));
		end
		if (s.rest == 0)
			s.rest = 31'd1;
		return s;
	endfunction

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RESIST_COMPRESSION)
			resist_sh = val;
		else
			definite_sh = val;
	endtask

	task automatic drain();
		while (pending_springs.size() > 0 || expected_results.size() > 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic add_random(int n);
		repeat (n) begin
			@(negedge clk);
			pending_springs.push_back(rand_spring());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RESIST_COMPRESSION;
		cfg_data = 1'b0;
		spring_ch.valid = 1'b0;
		spring_ch.pos_i_x = '0; spring_ch.pos_i_y = '0; spring_ch.pos_i_z = '0;
		spring_ch.pos_j_x = '0; spring_ch.pos_j_y = '0; spring_ch.pos_j_z = '0;
		spring_ch.rest_length = '0;
		spring_ch.spring_stiffness = '0;
		result_ch.ready = 1'b0;
		resist_sh = 1'b1;
		definite_sh = 1'b1;
		idle_on = 1;
		hold_request = 0;
		hold_left = 0;
		errors = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed springs at the reset settings.
		pending_springs.push_back(mk(0, 0, 0, 0, 0, 0, 31'd65536, 31'd65536));
		pending_springs.push_back(mk(5, 7, 9, 5, 7, 9, SAT_U31, SAT_U31));
		pending_springs.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1, SAT_U31));
		pending_springs.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, SAT_U31, SAT_U31));
		pending_springs.push_back(mk(0, 0, 0, 32'h0001_0000, 0, 0, 31'h0001_0000, 31'd4096));
		pending_springs.push_back(mk(0, 0, 0, 32'h0002_0000, 0, 0, 31'h0001_0000, 31'h0001_0000));
		pending_springs.push_back(mk(0, 0, 0, 32'hFFFF_8000, 0, 0, 31'h0001_0000, 31'h0001_0000));
		pending_springs.push_back(mk(0, 0, 0, 0, 32'h0003_0000, 32'hFFFC_0000,
			31'h0005_0000, 31'h0010_0000));
		pending_springs.push_back(mk(0, 0, 0, 0, 32'h0003_0000, 32'hFFFC_0000,
			31'h0002_0000, 31'h0010_0000));
		pending_springs.push_back(mk(32'h1234_5678, 32'hDEAD_BEEF, 32'h0BAD_F00D,
			32'h1234_5679, 32'hDEAD_BEEF, 32'h0BAD_F00D, 31'd1, 0));
		pending_springs.push_back(mk(0, 0, 0, 1, 1, 1, SAT_U31, SAT_U31));
		pending_springs.push_back(mk(0, 0, 0, 32'h0000_1000, 0, 0, 31'h0010_0000, 31'h0001_0000));
		pending_springs.push_back(mk(32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_0001,
			31'h0000_0100, 31'h4000_0000));
		pending_springs.push_back(mk(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 31'd1, 31'd1));
		pending_springs.push_back(mk(0, 0, 0, 32'h0100_0000, 0, 0, 31'h0000_0001, SAT_U31));
		drain();

		// Compression goes slack and the definite mode is off; no idling in this stretch.
		write_reg(REG_RESIST_COMPRESSION, 1'b0);
		write_reg(REG_DEFINITE_MODE, 1'b0);
		idle_on = 0;
		pending_springs.push_back(mk(0, 0, 0, 0, 0, 0, 31'd65536, 31'd65536));
		pending_springs.push_back(mk(0, 0, 0, 32'h0000_0200, 0, 0, 31'h0001_0000, 31'h0001_0000));
		pending_springs.push_back(mk(0, 0, 0, 32'h0000_0800, 0, 0, 31'h0001_0000, 31'h0001_0000));
		add_random(270);
		drain();
		idle_on = 1;

		// Definite mode on; long receiver hold-off while the sender keeps offering items.
		write_reg(REG_DEFINITE_MODE, 1'b1);
		add_random(20);
		@(negedge clk);
		hold_request = 1;
		@(negedge clk);
		hold_request = 0;
		add_random(250);
		drain();

		write_reg(REG_RESIST_COMPRESSION, 1'b1);
		write_reg(REG_DEFINITE_MODE, 1'b0);
		add_random(270);
		drain();

		write_reg(REG_DEFINITE_MODE, 1'b1);
		add_random(270);
		drain();

		write_reg(REG_RESIST_COMPRESSION, 1'b0);
		add_random(250);
		drain();

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

>>> sim.f
+incdir+rtl
rtl/ssf_pkg.sv
rtl/ssf_ifs.sv
rtl/ssf_sqrt.sv
rtl/ssf_div.sv
rtl/spring_stiffness_and_force_top.sv
rtl/ssf_chk.sv
tb/testbench.sv
